// File: src/spe_pkg.sv
// shared types, constants and constant functions for the positional encoding adder
`default_nettype none

package spe_pkg;

    // field widths
    localparam int X_W   = 32;
    localparam int POS_W = 12;
    localparam int DIM_W = 12;
    localparam int ERR_W = 2;
    localparam int MAXP_W = 13;

    // default sizes
    localparam int D_MODEL_DEF       = 512;
    localparam int MAX_LEN_DEF       = 4096;
    localparam int CORDIC_STAGES_DEF = 18;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_POSITION = 2'd1;
    localparam logic [ERR_W-1:0] ERR_DIM      = 2'd2;

    // register map, index taken from paddr[2]
    localparam logic REG_MAX_POSITIONS = 1'b0;
    localparam logic [MAXP_W-1:0] MAXPOS_RESET = 13'd4096;

    // fixed point constants
    localparam logic [63:0] LOG2_TENK_Q32 = 64'd57070290109;
    localparam logic [63:0] INV2PI_Q32    = 64'd683565276;
    localparam int CW = 34;
    localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

    // one result item
    typedef struct packed {
        logic signed [X_W-1:0] sum_value;
        logic [ERR_W-1:0]      error_code;
    } result_t;

    // cordic arctangent steps in turns, Q0.32
    function automatic logic [31:0] atan_turns(input int i);
        logic [31:0] a;
        case (i)
            0:  a = 32'd536870912;
            1:  a = 32'd316933406;
            2:  a = 32'd167458907;
            3:  a = 32'd85004756;
            4:  a = 32'd42667331;
            5:  a = 32'd21354465;
            6:  a = 32'd10679838;
            7:  a = 32'd5340245;
            8:  a = 32'd2670163;
            9:  a = 32'd1335087;
            10: a = 32'd667544;
            11: a = 32'd333772;
            12: a = 32'd166886;
            13: a = 32'd83443;
            14: a = 32'd41722;
            15: a = 32'd20861;
            16: a = 32'd10430;
            17: a = 32'd5215;
            18: a = 32'd2608;
            19: a = 32'd1304;
            20: a = 32'd652;
            21: a = 32'd326;
            22: a = 32'd163;
            23: a = 32'd81;
            24: a = 32'd41;
            25: a = 32'd20;
            26: a = 32'd10;
            27: a = 32'd5;
            28: a = 32'd3;
            29: a = 32'd1;
            30: a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

    // floor square root, used at elaboration only
    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bit_v;
        n = n_in;
        res = 64'd0;
        bit_v = 64'd1 << 62;
        while (bit_v > n)
            bit_v = bit_v >> 2;
        while (bit_v != 64'd0)
        begin
            if (n >= res + bit_v)
            begin
                n = n - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
            begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // pair frequency in Q0.32 turns from the Q32 exponent of 10000
    function automatic logic [31:0] pair_freq(input logic [63:0] e);
        int unsigned ei;
        logic [31:0] ef;
        logic [63:0] m;
        logic [63:0] r;
        logic [63:0] p;
        ei = int'(e[37:32]);
        ef = e[31:0];
        m = 64'd1 << 31;
        r = isqrt64(64'd1 << 61);
        for (int i = 1; i <= 32; i++)
        begin
            if (ef[32-i])
                m = (m * r) >> 31;
            r = isqrt64(r << 31);
        end
        if (31 + ei > 63)
            return 32'd0;
        p = (INV2PI_Q32 * m) >> (31 + ei);
        return p[31:0];
    endfunction

endpackage

`default_nettype wire

// File: src/spe_if.sv
// item channels: activation input and encoded result output
`default_nettype none

interface spe_in_if
    import spe_pkg::*;
    ;
    logic                  valid;
    logic                  ready;
    logic signed [X_W-1:0] x_value;
    logic [POS_W-1:0]      position;
    logic [DIM_W-1:0]      dim_index;

    modport source (output valid, output x_value, output position, output dim_index,
                    input ready);
    modport sink (input valid, input x_value, input position, input dim_index,
                  output ready);
endinterface

interface spe_out_if
    import spe_pkg::*;
    ;
    logic                  valid;
    logic                  ready;
    logic signed [X_W-1:0] sum_value;
    logic [ERR_W-1:0]      error_code;

    modport source (output valid, output sum_value, output error_code, input ready);
    modport sink (input valid, input sum_value, input error_code, output ready);
endinterface

`default_nettype wire

// File: src/sinusoidal_position_encoding_add.sv
// sinusoidal positional encoding adder: frequency rom, phase multiply, cordic, saturating add
// registers from input to result: stage 1, cordic input, one per cordic stage, encoding, output
// throughput: one item per cycle unless stalled; one cordic iteration per pipeline stage
// stalls: a two-entry output buffer; ready drops only while both entries are full
// reset: rst_n asynchronous, clears all valid bits and sets max_positions to 4096
`default_nettype none

module sinusoidal_position_encoding_add
    import spe_pkg::*;
#(
    parameter int D_MODEL       = D_MODEL_DEF,
    parameter int MAX_LEN       = MAX_LEN_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    spe_in_if.sink           act,
    spe_out_if.source        res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int NPAIR = (D_MODEL + 1) / 2;
    localparam int IDX_W = (NPAIR > 1) ? $clog2(NPAIR) : 1;
    localparam int N     = CORDIC_STAGES;

    // configuration register
    logic [MAXP_W-1:0] max_positions_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_positions_reg <= MAXPOS_RESET;
        else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_POSITIONS)
            max_positions_reg <= pwdata[MAXP_W-1:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_POSITIONS) ? {19'd0, max_positions_reg} : 32'd0;

    // pipeline advance, held while the output skid entry is full
    logic en;
    logic skid_v_reg;
    assign en = !skid_v_reg;
    assign act.ready = en;

    // pair frequency rom, built at elaboration
    logic [31:0] freq_rom [NPAIR];

    for (genvar k = 0; k < NPAIR; k++)
    begin : g_rom
        localparam logic [63:0] EXP_Q32 = (64'(2 * k) * LOG2_TENK_Q32) / 64'(D_MODEL);
        assign freq_rom[k] = pair_freq(EXP_Q32);
    end

    // input checks
    logic             pos_bad;
    logic             dim_bad;
    logic [ERR_W-1:0] in_err;
    logic [IDX_W-1:0] rom_idx;

    always_comb
    begin
        pos_bad = ({1'b0, act.position} >= max_positions_reg) ||
                  (32'(act.position) >= 32'(MAX_LEN));
        dim_bad = 32'(act.dim_index) >= 32'(D_MODEL);
        if (pos_bad)
            in_err = ERR_POSITION;
        else if (dim_bad)
            in_err = ERR_DIM;
        else
            in_err = ERR_NONE;
        rom_idx = (in_err == ERR_NONE) ? IDX_W'(act.dim_index >> 1) : '0;
    end

    // stage 1: rom read and error code
    logic                  s1_v_reg;
    logic signed [X_W-1:0] s1_x_reg;
    logic [POS_W-1:0]      s1_pos_reg;
    logic                  s1_odd_reg;
    logic [ERR_W-1:0]      s1_err_reg;
    logic [31:0]           s1_freq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (en)
            s1_v_reg <= act.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_x_reg    <= act.x_value;
            s1_pos_reg  <= act.position;
            s1_odd_reg  <= act.dim_index[0];
            s1_err_reg  <= in_err;
            s1_freq_reg <= freq_rom[rom_idx];
        end
    end

    // stage 2: phase multiply, cosine offset and half-turn reduction
    logic [43:0] prod;
    logic [31:0] phase;
    logic        phase_neg;
    logic [31:0] phase_red;

    always_comb
    begin
        prod      = 44'(s1_pos_reg) * 44'(s1_freq_reg);
        phase     = prod[31:0] + (s1_odd_reg ? 32'h4000_0000 : 32'h0);
        phase_neg = phase[31] ^ phase[30];
        phase_red = {phase[31] ^ phase_neg, phase[30:0]};
    end

    // cordic pipeline, index 0 holds the reduced angle
    logic                  cv_reg   [N+1];
    logic signed [CW-1:0]  cx_reg   [N+1];
    logic signed [CW-1:0]  cy_reg   [N+1];
    logic signed [CW-1:0]  cz_reg   [N+1];
    logic signed [X_W-1:0] cact_reg [N+1];
    logic                  cneg_reg [N+1];
    logic [ERR_W-1:0]      cerr_reg [N+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cv_reg[0] <= 1'b0;
        else if (en)
            cv_reg[0] <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg[0]   <= CORDIC_X0;
            cy_reg[0]   <= '0;
            cz_reg[0]   <= {{(CW-32){phase_red[31]}}, phase_red};
            cact_reg[0] <= s1_x_reg;
            cneg_reg[0] <= phase_neg;
            cerr_reg[0] <= s1_err_reg;
        end
    end

    for (genvar g = 0; g < N; g++)
    begin : g_cordic
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [CW-1:0] ang;

        assign dx  = cy_reg[g] >>> g;
        assign dy  = cx_reg[g] >>> g;
        assign ang = {{(CW-32){1'b0}}, atan_turns(g)};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cv_reg[g+1] <= 1'b0;
            else if (en)
                cv_reg[g+1] <= cv_reg[g];
        end

        // rotate toward zero residual angle
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!cz_reg[g][CW-1])
                begin
                    cx_reg[g+1] <= cx_reg[g] - dx;
                    cy_reg[g+1] <= cy_reg[g] + dy;
                    cz_reg[g+1] <= cz_reg[g] - ang;
                end
                else
                begin
                    cx_reg[g+1] <= cx_reg[g] + dx;
                    cy_reg[g+1] <= cy_reg[g] - dy;
                    cz_reg[g+1] <= cz_reg[g] + ang;
                end
                cact_reg[g+1] <= cact_reg[g];
                cneg_reg[g+1] <= cneg_reg[g];
                cerr_reg[g+1] <= cerr_reg[g];
            end
        end
    end

    // encoding: round to Q1.16, clamp, undo the half-turn reduction
    logic signed [CW-1:0] y_round;
    logic signed [CW-1:0] y_q16;
    logic signed [CW-1:0] y_clamp;
    logic signed [17:0]   enc_next;

    always_comb
    begin
        y_round = cy_reg[N] + 34'sd8192;
        y_q16   = y_round >>> 14;
        if (y_q16 > 34'sd65536)
            y_clamp = 34'sd65536;
        else if (y_q16 < -34'sd65536)
            y_clamp = -34'sd65536;
        else
            y_clamp = y_q16;
        enc_next = cneg_reg[N] ? 18'(-y_clamp) : 18'(y_clamp);
    end

    logic                  e_v_reg;
    logic signed [17:0]    enc_reg;
    logic signed [X_W-1:0] e_x_reg;
    logic [ERR_W-1:0]      e_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_v_reg <= 1'b0;
        else if (en)
            e_v_reg <= cv_reg[N];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            enc_reg   <= enc_next;
            e_x_reg   <= cact_reg[N];
            e_err_reg <= cerr_reg[N];
        end
    end

    // saturating add, zero on error
    logic signed [X_W:0] sum_wide;
    result_t             fin;

    always_comb
    begin
        sum_wide = {e_x_reg[X_W-1], e_x_reg} + {{(X_W-17){enc_reg[17]}}, enc_reg};
        if (e_err_reg != ERR_NONE)
            fin.sum_value = '0;
        else if (sum_wide[X_W] != sum_wide[X_W-1])
            fin.sum_value = sum_wide[X_W] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
            fin.sum_value = sum_wide[X_W-1:0];
        fin.error_code = e_err_reg;
    end

    // two-entry output buffer: main register and skid entry
    logic    out_v_reg;
    logic    out_v_next;
    logic    skid_v_next;
    result_t out_d_reg;
    result_t out_d_next;
    result_t skid_d_reg;
    result_t skid_d_next;

    always_comb
    begin
        out_v_next  = out_v_reg;
        out_d_next  = out_d_reg;
        skid_v_next = skid_v_reg;
        skid_d_next = skid_d_reg;
        if (en)
        begin
            if (out_v_reg && !res.ready)
            begin
                skid_v_next = e_v_reg;
                skid_d_next = fin;
            end
            else
            begin
                out_v_next = e_v_reg;
                out_d_next = fin;
            end
        end
        else if (res.ready)
        begin
            out_v_next  = 1'b1;
            out_d_next  = skid_d_reg;
            skid_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_d_reg  <= out_d_next;
        skid_d_reg <= skid_d_next;
    end

    assign res.valid      = out_v_reg;
    assign res.sum_value  = out_d_reg.sum_value;
    assign res.error_code = out_d_reg.error_code;

endmodule

`default_nettype wire

// File: src/spe_checker.sv
// port-level checks of the positional encoding adder, bound to the top level
`default_nettype none

module spe_checker
    import spe_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic signed [X_W-1:0] sum_value,
    input wire logic [ERR_W-1:0]      error_code
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sum_value) && $stable(error_code))
        else $error("result item changed while stalled");

    // a rejected item carries a zero sum
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ERR_NONE |-> sum_value == '0)
        else $error("nonzero sum on error");

    // input backpressure only with a result waiting
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty output");

    // a full buffer stays full until the sink takes an item
    a_ready_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready && !out_ready |=> !in_ready)
        else $error("buffer drained without a take");

    // an offered item always sees a defined ready
    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> !$isunknown(in_ready))
        else $error("input ready unknown while an item is offered");

endmodule

bind sinusoidal_position_encoding_add spe_checker u_spe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (act.valid),
    .in_ready   (act.ready),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .sum_value  (res.sum_value),
    .error_code (res.error_code)
);

`default_nettype wire

// File: bench/tb_sinusoidal_position_encoding_add.sv
// testbench for the positional encoding adder: directed and random items checked against a local model
`timescale 1ns / 100ps

module tb_sinusoidal_position_encoding_add;
    import spe_pkg::*;

    localparam int D_MODEL      = 512;
    localparam int MAX_LEN      = 4096;
    localparam int STAGES       = 18;
    localparam int LATENCY      = STAGES + 4;
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 11;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 200;

    // register addresses
    localparam logic [2:0] ADDR_MAX_POSITIONS = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED      = 3'd4;

    // fixed point constants of the encoding
    localparam logic [63:0] LOG2_10K      = 64'd57070290109;
    localparam logic [63:0] TURNS_PER_RAD = 64'd683565276;
    localparam longint      GAIN_X0       = 652032874;

    // arctangent per cordic step in turns, Q0.32, step 0 in the low word
    localparam logic [STAGES*32-1:0] ATAN_STEPS = {
        32'd5215, 32'd10430, 32'd20861, 32'd41722, 32'd83443, 32'd166886,
        32'd333772, 32'd667544, 32'd1335087, 32'd2670163, 32'd5340245,
        32'd10679838, 32'd21354465, 32'd42667331, 32'd85004756,
        32'd167458907, 32'd316933406, 32'd536870912
    };

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    spe_in_if  act_ch ();
    spe_out_if res_ch ();

    sinusoidal_position_encoding_add dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .act     (act_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [31:0]       turn_rate [0:D_MODEL/2-1];
    logic [MAXP_W-1:0] pos_limit;
    result_t           pending_sums [$];
    int                errors;
    int                quiet_cycles;
    bit                sender_idles;
    bit                receiver_idles;
    bit                hold_req;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // floor square root, one result bit per pass
    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] trial;
        root = 64'd0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    // per pair rotation rate in turns per position, Q0.32
    initial
    begin : build_rates
        logic [63:0] expo;
        logic [63:0] mant;
        logic [63:0] root;
        int unsigned whole;
        for (int k = 0; k < D_MODEL / 2; k++)
        begin
            expo = (64'(2 * k) * LOG2_10K) / 64'(D_MODEL);
            whole = expo[37:32];
            mant = 64'd1 << 31;
            root = floor_sqrt(64'd1 << 61);
            for (int i = 1; i <= 32; i++)
            begin
                if (expo[32-i])
                    mant = (mant * root) >> 31;
                root = floor_sqrt(root << 31);
            end
            turn_rate[k] = 32'((TURNS_PER_RAD * mant) >> (31 + whole));
        end
    end

    // expected result of one item: range checks, phase, cordic, saturating add
    function automatic result_t predict_encoded_sum(input logic signed [31:0] x,
                                                    input logic [11:0] pos,
                                                    input logic [11:0] dim);
        result_t r;
        logic [63:0] prod;
        logic [31:0] ph;
        bit flip;
        longint cx;
        longint cy;
        longint cz;
        longint dx;
        longint dy;
        longint enc;
        longint total;
        r.sum_value = '0;
        r.error_code = ERR_NONE;
        if (pos >= pos_limit || pos >= MAX_LEN)
        begin
            r.error_code = ERR_POSITION;
            return r;
        end
        if (dim >= D_MODEL)
        begin
            r.error_code = ERR_DIM;
            return r;
        end
        prod = 64'(pos) * 64'(turn_rate[dim[11:1]]);
        ph = prod[31:0];
        // cosine is sine a quarter turn ahead
        if (dim[0])
            ph = ph + 32'h4000_0000;
        // fold the back half circle onto the front, negate at the end
        flip = 1'b0;
        if (((ph + 32'h4000_0000) & 32'h8000_0000) != 32'd0)
        begin
            flip = 1'b1;
            ph = ph - 32'h8000_0000;
        end
        cz = longint'($signed(ph));
        cx = GAIN_X0;
        cy = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cz >= 0)
            begin
                cx = cx - dx;
                cy = cy + dy;
                cz = cz - longint'(ATAN_STEPS[i*32 +: 32]);
            end
            else
            begin
                cx = cx + dx;
                cy = cy - dy;
                cz = cz + longint'(ATAN_STEPS[i*32 +: 32]);
            end
        end
        enc = (cy + 8192) >>> 14;
        if (enc > 65536)
            enc = 65536;
        if (enc < -65536)
            enc = -65536;
        if (flip)
            enc = -enc;
        total = longint'(x) + enc;
        if (total > 64'sd2147483647)
            total = 64'sd2147483647;
        if (total < -64'sd2147483648)
            total = -64'sd2147483648;
        r.sum_value = 32'(total);
        return r;
    endfunction

    // idle length: mostly short, now and then long
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int sender_gap();
        if (!sender_idles || $urandom_range(0, 1) == 0)
            return 0;
        return idle_len();
    endfunction

    // offer one item and wait until it is taken
    task automatic send_item(input logic signed [31:0] x, input logic [11:0] pos,
                             input logic [11:0] dim);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            act_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        act_ch.valid <= 1'b1;
        act_ch.x_value <= x;
        act_ch.position <= pos;
        act_ch.dim_index <= dim;
        @(posedge clk);
        while (!act_ch.ready)
            @(posedge clk);
    endtask

    // random item biased toward saturation, the position limit and dimension edges
    task automatic send_random_item();
        logic signed [31:0] x;
        logic [11:0] pos;
        logic [11:0] dim;
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: x = 32'h7FFF_FFFF - $urandom_range(0, 131071);
            1: x = 32'h8000_0000 + $urandom_range(0, 131071);
            2, 3: x = $urandom_range(0, 524288) - 262144;
            default: x = $urandom;
        endcase
        sel = $urandom_range(0, 9);
        if (sel == 7 && pos_limit != '0)
            pos = 12'(pos_limit - 1 + $urandom_range(0, 1));
        else if (sel >= 8)
            pos = $urandom_range(0, 63);
        else
            pos = $urandom_range(0, 4095);
        sel = $urandom_range(0, 19);
        if (sel < 17)
            dim = $urandom_range(0, D_MODEL - 1);
        else if (sel == 17)
            dim = $urandom_range(D_MODEL - 2, D_MODEL + 1);
        else
            dim = $urandom_range(D_MODEL, 4095);
        send_item(x, pos, dim);
    endtask

    // stop offering and wait until every result is back
    task automatic drain();
        act_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // register write: setup cycle, then access cycle
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_MAX_POSITIONS)
            pos_limit = data[MAXP_W-1:0];
    endtask

    // field extremes, sine and cosine, saturation, dimension errors at reset limit
    task automatic test_encoding_extremes();
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        send_item(32'sd0, 12'd0, 12'd0);
        send_item(32'sd0, 12'd0, 12'd1);
        send_item(32'h7FFF_FFFF, 12'd0, 12'd1);
        send_item(32'h8000_0000, 12'd5, 12'd0);
        send_item(32'h8000_0000, 12'd0, 12'd0);
        send_item(32'hFFFF_0000, 12'd0, 12'd1);
        send_item(32'hFFFF_FFFF, 12'd4095, 12'd0);
        send_item(32'h0001_8000, 12'd4095, 12'd511);
        send_item(32'h1234_5678, 12'd4095, 12'd510);
        send_item(32'sd0, 12'd1, 12'd0);
        send_item(32'sd0, 12'd100, 12'd1);
        send_item(32'sd0, 12'd2047, 12'd256);
        send_item(32'h7FFF_8000, 12'd3, 12'd2);
        send_item(32'sd0, 12'd0, 12'd512);
        send_item(32'h7FFF_FFFF, 12'd4095, 12'd4095);
        send_item(32'h8000_0000, 12'd2730, 12'hAAA);
    endtask

    // position limit: reject all, limit of one, top edge, masked write, unmapped write
    task automatic test_position_limit();
        drain();
        write_reg(ADDR_MAX_POSITIONS, 32'd0);
        send_item(32'sd0, 12'd0, 12'd0);
        // position error wins over a dimension error
        send_item(32'h7FFF_FFFF, 12'd0, 12'd4095);
        drain();
        write_reg(ADDR_MAX_POSITIONS, 32'd1);
        send_item(32'h0001_0000, 12'd0, 12'd1);
        send_item(32'sd0, 12'd1, 12'd0);
        drain();
        write_reg(ADDR_MAX_POSITIONS, 32'd4095);
        send_item(32'sd0, 12'd4094, 12'd7);
        send_item(32'sd0, 12'd4095, 12'd7);
        drain();
        // bits above the register width are dropped
        write_reg(ADDR_MAX_POSITIONS, 32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF, 12'd4095, 12'd3);
        drain();
        write_reg(ADDR_UNMAPPED, 32'd0);
        send_item(32'sd0, 12'd4095, 12'd4);
    endtask

    // random items over several limit settings, with and without idling
    task automatic test_random_traffic();
        logic [31:0] limit_word;
        int batch;
        for (int phase_i = 0; phase_i < 8; phase_i++)
        begin
            case (phase_i)
                0: limit_word = 32'd4096;
                1: limit_word = 32'd8191;
                2: limit_word = 32'd1;
                3: limit_word = $urandom;
                4: limit_word = $urandom_range(2048, 4095);
                5: limit_word = 32'd0;
                6: limit_word = $urandom_range(1, 4096) | ($urandom << MAXP_W);
                default: limit_word = 32'd4096;
            endcase
            drain();
            write_reg(ADDR_MAX_POSITIONS, limit_word);
            sender_idles = (phase_i % 3) != 2;
            receiver_idles = (phase_i % 4) != 3;
            batch = (phase_i == 2 || phase_i == 5) ? 40 : 170;
            repeat (batch) send_random_item();
        end
    endtask

    // receiver holds off long while items keep coming, so the input stalls
    task automatic test_output_backpressure();
        drain();
        write_reg(ADDR_MAX_POSITIONS, 32'd4096);
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        hold_req = 1'b1;
        repeat (60) send_random_item();
    endtask

    // result side ready: random stalls, or one long hold on request
    initial
    begin : result_taker
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (receiver_idles && $urandom_range(0, 3) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (idle_len()) @(posedge clk);
            end
            else
            begin
                res_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // record the expected result of each accepted item
    always @(posedge clk)
    begin
        if (act_ch.valid && act_ch.ready)
            pending_sums.push_back(predict_encoded_sum(act_ch.x_value, act_ch.position,
                                                       act_ch.dim_index));
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_sums.size() == 0)
            begin
                $error("result item with none expected: sum_value %0d error_code %0d",
                       res_ch.sum_value, res_ch.error_code);
                errors++;
            end
            else
            begin
                want = pending_sums.pop_front();
                if (res_ch.sum_value !== want.sum_value)
                begin
                    $error("sum_value expected %0d got %0d", want.sum_value,
                           res_ch.sum_value);
                    errors++;
                end
                if (res_ch.error_code !== want.error_code)
                begin
                    $error("error_code expected %0d got %0d", want.error_code,
                           res_ch.error_code);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if ((act_ch.valid && act_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        errors = 0;
        pos_limit = MAXPOS_RESET;
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        hold_req = 1'b0;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_MAX_POSITIONS;
        pwdata <= 32'd0;
        act_ch.valid <= 1'b0;
        act_ch.x_value <= '0;
        act_ch.position <= '0;
        act_ch.dim_index <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_encoding_extremes();
        test_position_limit();
        test_random_traffic();
        test_output_backpressure();
        drain();
        repeat (LATENCY) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
src/spe_pkg.sv
src/spe_if.sv
src/sinusoidal_position_encoding_add.sv
src/spe_checker.sv
bench/tb_sinusoidal_position_encoding_add.sv
